### design/vfsr_pkg.sv
`default_nettype none

package vfsr_pkg;

  localparam int SLOT_COUNT_DEF = 3;

  localparam logic [15:0] HOLD_RESET = 16'd15;

  localparam logic REG_HOLD   = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_DROP    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  typedef struct packed {
    logic [15:0] seq_number;
    logic [31:0] time_stamp;
    logic        key_frame;
    logic [31:0] frame_offset;
    logic [31:0] frame_length;
    logic [15:0] payload_length;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  slot_index;
    logic [31:0] write_offset;
    logic [15:0] write_length;
    logic [15:0] out_seq;
    logic [31:0] out_time;
    logic [31:0] out_full_length;
    logic [31:0] out_received;
    logic        out_key;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] stamp;
    logic        key;
    logic [31:0] full;
    logic [31:0] got;
  } slot_t;

  typedef struct packed {
    logic load;
    logic add;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/video_frame_slot_reassembler.sv
`default_nettype none

// Video frame slot reassembler. Each accepted item is one packet header; the
// block keeps up to SLOT_COUNT frames in a row of slot cells, oldest in cell 0,
// and answers each item with one to three result items (write, drop, release,
// invalid), the final one marked by last. The controller walks a header through
// the states lookup (which may evict the oldest frame), pick, write and release,
// each emitting at most one result and waiting while the result port is stalled;
// every release compacts the cell row in that same cycle. A new header is taken
// only once the block is back in idle.
// Configuration: index 0 sets the keyframe hold time in ms, index 1 enables
// reception; write only while the block is idle.
module video_frame_slot_reassembler #(
  parameter int SLOT_COUNT = vfsr_pkg::SLOT_COUNT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pkt_valid,
  output logic                pkt_ready,
  input  wire vfsr_pkg::in_t  pkt,
  output logic                res_valid,
  input  wire logic           res_ready,
  output vfsr_pkg::out_t      res,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [15:0]    cfg_data
);
  import vfsr_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int UW    = $clog2(SLOT_COUNT + 1);
  localparam int IW2   = IDX_W + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_REL   = 3'd4;

  logic [2:0]       state, state_next;
  logic [UW-1:0]    used, used_next;
  logic [IDX_W-1:0] sel, sel_next;
  logic             fresh, fresh_next;
  logic [15:0]      hold;
  logic             enable;
  in_t              pkt_q;

  slot_t            slots [SLOT_COUNT];
  slot_t            nb    [SLOT_COUNT];
  cell_ctrl_t       cell_ctrl [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] cell_hit;
  logic [SLOT_COUNT-1:0] cell_done;

  logic             load_en, add_en, shift_en;
  logic [IDX_W-1:0] shift_idx;
  logic             emit;
  out_t             emit_item;

  logic             out_free;
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] last_idx, used_idx;
  logic             late, full, multipart, invalid, hold_ok, evict, done_s, rel;
  logic [32:0]      hold_sum;

  function automatic logic [1:0] low2(input logic [IDX_W-1:0] v);
    logic [IW2-1:0] w;
    w = IW2'(v);
    return w[1:0];
  endfunction

  function automatic out_t plain_item(input logic [1:0] kind, input logic last);
    out_t r;
    r      = '0;
    r.kind = kind;
    r.last = last;
    return r;
  endfunction

  function automatic out_t release_item(input slot_t sl, input logic [IDX_W-1:0] idx,
                                        input logic last);
    out_t r;
    r                 = '0;
    r.kind            = KIND_RELEASE;
    r.slot_index      = low2(idx);
    r.out_seq         = sl.seq;
    r.out_time        = sl.stamp;
    r.out_full_length = sl.full;
    r.out_received    = sl.got;
    r.out_key         = sl.key;
    r.last            = last;
    return r;
  endfunction

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    if (i == SLOT_COUNT - 1) begin : g_end
      assign nb[i] = '0;
    end else begin : g_mid
      assign nb[i] = slots[i+1];
    end

    assign cell_ctrl[i].load  = load_en && (sel == IDX_W'(i));
    assign cell_ctrl[i].add   = add_en && (sel == IDX_W'(i));
    assign cell_ctrl[i].shift = shift_en && (IDX_W'(i) >= shift_idx);

    vfsr_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .pkt  (pkt_q),
      .ctrl (cell_ctrl[i]),
      .nb   (nb[i]),
      .slot (slots[i]),
      .hit  (cell_hit[i]),
      .done (cell_done[i])
    );
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (cell_hit[i] && (UW'(i) < used)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    out_free  = !res_valid || res_ready;
    last_idx  = IDX_W'(used - UW'(1));
    used_idx  = IDX_W'(used);
    late      = (used != '0) && (slots[last_idx].stamp > pkt_q.time_stamp);
    full      = used == UW'(SLOT_COUNT);
    multipart = pkt_q.frame_length != {16'b0, pkt_q.payload_length};
    invalid   = pkt_q.frame_offset >= pkt_q.frame_length;
    hold_sum  = {1'b0, slots[0].stamp} + {17'b0, hold};
    hold_ok   = hold_sum <= {1'b0, pkt_q.time_stamp};
    evict     = pkt_q.key_frame || !slots[0].key || (slots[0].got == slots[0].full) ||
                hold_ok;
    done_s    = fresh ? ({16'b0, pkt_q.payload_length} == pkt_q.frame_length)
                      : cell_done[sel];
    rel       = done_s && !(slots[0].key && (sel != '0));
  end

  always_comb begin
    state_next = state;
    used_next  = used;
    sel_next   = sel;
    fresh_next = fresh;
    load_en    = 1'b0;
    add_en     = 1'b0;
    shift_en   = 1'b0;
    shift_idx  = '0;
    emit       = 1'b0;
    emit_item  = '0;
    unique case (state)
      S_IDLE: begin
        if (pkt_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          if (!enable) begin
            emit       = 1'b1;
            emit_item  = plain_item(KIND_DROP, 1'b1);
            state_next = S_IDLE;
          end else if (invalid) begin
            emit       = 1'b1;
            emit_item  = plain_item(KIND_INVALID, 1'b1);
            state_next = S_IDLE;
          end else if (multipart && hit_any) begin
            sel_next   = hit_idx;
            fresh_next = 1'b0;
            state_next = S_WRITE;
          end else if (!full) begin
            if (late) begin
              emit       = 1'b1;
              emit_item  = plain_item(KIND_DROP, 1'b1);
              state_next = S_IDLE;
            end else begin
              sel_next   = used_idx;
              fresh_next = 1'b1;
              state_next = S_WRITE;
            end
          end else if (evict) begin
            emit       = 1'b1;
            emit_item  = release_item(slots[0], '0, 1'b0);
            shift_en   = 1'b1;
            shift_idx  = '0;
            used_next  = used - UW'(1);
            state_next = S_PICK;
          end else begin
            emit       = 1'b1;
            emit_item  = plain_item(KIND_DROP, 1'b1);
            state_next = S_IDLE;
          end
        end
      end
      S_PICK: begin
        if (out_free) begin
          if (late) begin
            emit       = 1'b1;
            emit_item  = plain_item(KIND_DROP, 1'b1);
            state_next = S_IDLE;
          end else begin
            sel_next   = used_idx;
            fresh_next = 1'b1;
            state_next = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_item              = '0;
          emit_item.kind         = KIND_WRITE;
          emit_item.slot_index   = low2(sel);
          emit_item.write_offset = pkt_q.frame_offset;
          emit_item.write_length = pkt_q.payload_length;
          emit_item.last         = !rel;
          load_en                = fresh;
          add_en                 = !fresh;
          if (fresh) begin
            used_next = used + UW'(1);
          end
          state_next = rel ? S_REL : S_IDLE;
        end
      end
      S_REL: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_item  = release_item(slots[sel], sel, 1'b1);
          shift_en   = 1'b1;
          shift_idx  = sel;
          used_next  = used - UW'(1);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign pkt_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      sel       <= '0;
      fresh     <= 1'b0;
      hold      <= HOLD_RESET;
      enable    <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      sel   <= sel_next;
      fresh <= fresh_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HOLD:   hold   <= cfg_data;
          REG_ENABLE: enable <= cfg_data[0];
          default:    hold   <= hold;
        endcase
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && pkt_ready) begin
      pkt_q <= pkt;
    end
    if (emit) begin
      res <= emit_item;
    end
  end

endmodule

`default_nettype wire

### design/vfsr_cell.sv
`default_nettype none

module vfsr_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire vfsr_pkg::in_t      pkt,
  input  wire vfsr_pkg::cell_ctrl_t ctrl,
  input  wire vfsr_pkg::slot_t    nb,
  output vfsr_pkg::slot_t         slot,
  output logic                    hit,
  output logic                    done
);
  import vfsr_pkg::*;

  logic [32:0] sum;
  logic [31:0] got_sum;

  always_comb begin
    sum     = {1'b0, slot.got} + {17'b0, pkt.payload_length};
    got_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    done    = got_sum == pkt.frame_length;
    hit     = (slot.seq == pkt.seq_number) && (slot.stamp == pkt.time_stamp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (ctrl.shift) begin
      slot <= nb;
    end else if (ctrl.load) begin
      slot.seq   <= pkt.seq_number;
      slot.stamp <= pkt.time_stamp;
      slot.key   <= pkt.key_frame;
      slot.full  <= pkt.frame_length;
      slot.got   <= {16'b0, pkt.payload_length};
    end else if (ctrl.add) begin
      slot.got <= got_sum;
    end
  end

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import vfsr_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int PICK_DROP_INCOMING = -2;
  localparam int PICK_EVICT_OLDEST = -1;

  typedef struct {
    logic [15:0] seq;
    logic [31:0] stamp;
    logic        key;
    logic [31:0] total;
    logic [31:0] sent;
  } frame_plan_t;

  class slot_table_tracker;
    logic [15:0] hold_ms;
    logic        rx_on;
    int unsigned used;
    slot_t       slots [SLOTS];
    out_t        pending_results [$];
    int          errors;
    int          packets;
    int          kind_seen [4];

    function new();
      hold_ms = HOLD_RESET;
      rx_on = 1'b1;
      used = 0;
      foreach (slots[i]) slots[i] = '0;
      errors = 0;
      packets = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == REG_HOLD) begin
        hold_ms = data;
      end else begin
        rx_on = data[0];
      end
    endfunction

    function out_t blank(logic [1:0] kind, int unsigned slot);
      out_t r;
      r = '0;
      r.kind = kind;
      r.slot_index = slot[1:0];
      return r;
    endfunction

    function void release_slot(int unsigned idx);
      out_t r;
      if (idx >= used) return;
      r = blank(KIND_RELEASE, idx);
      r.out_seq = slots[idx].seq;
      r.out_time = slots[idx].stamp;
      r.out_full_length = slots[idx].full;
      r.out_received = slots[idx].got;
      r.out_key = slots[idx].key;
      pending_results.push_back(r);
      for (int unsigned i = idx; i + 1 < used; i++) slots[i] = slots[i + 1];
      used--;
      slots[used] = '0;
    endfunction

    function int pick_slot(logic [15:0] seq, logic [31:0] stamp, logic key, logic multipart);
      if (multipart) begin
        for (int i = 0; i < used; i++) begin
          if (slots[i].seq == seq && slots[i].stamp == stamp) return i;
        end
      end
      if (used < SLOTS) begin
        if (used > 0 && slots[used - 1].stamp > stamp) return PICK_DROP_INCOMING;
        return used;
      end
      if (key || !slots[0].key || slots[0].got == slots[0].full) return PICK_EVICT_OLDEST;
      if ({1'b0, slots[0].stamp} + {17'd0, hold_ms} <= {1'b0, stamp}) return PICK_EVICT_OLDEST;
      return PICK_DROP_INCOMING;
    endfunction

    function void note_packet(in_t p);
      out_t r;
      int pick;
      int unsigned s;
      logic [32:0] sum;
      packets++;
      if (!rx_on) begin
        pending_results.push_back(blank(KIND_DROP, 0));
      end else if (p.frame_offset >= p.frame_length) begin
        pending_results.push_back(blank(KIND_INVALID, 0));
      end else begin
        pick = pick_slot(p.seq_number, p.time_stamp, p.key_frame,
                         p.frame_length != {16'd0, p.payload_length});
        if (pick == PICK_EVICT_OLDEST) begin
          release_slot(0);
          pick = pick_slot(p.seq_number, p.time_stamp, p.key_frame, 1'b0);
        end
        if (pick < 0) begin
          pending_results.push_back(blank(KIND_DROP, 0));
        end else begin
          s = pick;
          if (s >= used) begin
            s = used;
            slots[s] = {p.seq_number, p.time_stamp, p.key_frame, p.frame_length, 32'd0};
            used++;
          end
          r = blank(KIND_WRITE, s);
          r.write_offset = p.frame_offset;
          r.write_length = p.payload_length;
          pending_results.push_back(r);
          sum = {1'b0, slots[s].got} + p.payload_length;
          slots[s].got = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (slots[s].got == p.frame_length && !(slots[0].key && s != 0)) release_slot(s);
        end
      end
      r = pending_results[pending_results.size() - 1];
      r.last = 1'b1;
      pending_results[pending_results.size() - 1] = r;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: kind %0d slot %0d", got.kind, got.slot_index);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      kind_seen[want.kind]++;
      compare_field("kind", want.kind, got.kind);
      compare_field("slot_index", want.slot_index, got.slot_index);
      compare_field("write_offset", want.write_offset, got.write_offset);
      compare_field("write_length", want.write_length, got.write_length);
      compare_field("out_seq", want.out_seq, got.out_seq);
      compare_field("out_time", want.out_time, got.out_time);
      compare_field("out_full_length", want.out_full_length, got.out_full_length);
      compare_field("out_received", want.out_received, got.out_received);
      compare_field("out_key", want.out_key, got.out_key);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        pkt_valid;
  logic        pkt_ready;
  in_t         pkt;
  logic        res_valid;
  logic        res_ready;
  out_t        res;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  slot_table_tracker sb;
  logic              idling_on;
  logic [15:0]       seq_cursor;
  logic [31:0]       ts_cursor;
  frame_plan_t       plans [$];

  video_frame_slot_reassembler u_dut (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res);
  end

  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst) begin
        if (idling_on && $urandom_range(0, 3) == 0) begin
          res_ready <= 1'b0;
          repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** video_frame_slot_reassembler: FAILED **");
    $finish;
  end

  task automatic send_pkt(in_t p);
    pkt <= p;
    pkt_valid <= 1'b1;
    @(posedge clk);
    while (!pkt_ready) @(posedge clk);
    sb.note_packet(p);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      pkt_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic send_fields(logic [15:0] seq, logic [31:0] stamp, logic key,
                             logic [31:0] off, logic [31:0] flen, logic [15:0] plen);
    in_t p;
    p.seq_number = seq;
    p.time_stamp = stamp;
    p.key_frame = key;
    p.frame_offset = off;
    p.frame_length = flen;
    p.payload_length = plen;
    send_pkt(p);
  endtask

  task automatic write_config(logic idx, logic [15:0] data);
    pkt_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Mostly interleaved multipart frames with random cut points; some
  // single-packet frames, repeated parts, late frames and raw noise.
  function automatic in_t next_stream_packet();
    in_t         p;
    frame_plan_t f;
    int          roll;
    int          idx;
    logic [31:0] chunk;
    roll = $urandom_range(0, 99);
    idx = -1;
    p = '0;
    if (roll < 12) begin
      p.seq_number = 16'($urandom);
      p.key_frame = 1'($urandom);
      p.frame_offset = $urandom;
      p.frame_length = $urandom;
      p.payload_length = 16'($urandom);
      p.time_stamp = ts_cursor - $urandom_range(0, 30);
      if (roll < 3) p.time_stamp = $urandom;
    end else if (roll < 20) begin
      seq_cursor++;
      ts_cursor += $urandom_range(0, 6);
      p.seq_number = seq_cursor;
      p.time_stamp = ts_cursor;
      p.key_frame = ($urandom_range(0, 3) == 0);
      p.payload_length = 16'($urandom_range(1, 1500));
      p.frame_length = {16'd0, p.payload_length};
      p.frame_offset = 0;
    end else if (plans.size() == 0 || roll < 38) begin
      seq_cursor++;
      if ($urandom_range(0, 9) == 0) begin
        f.stamp = ts_cursor - $urandom_range(1, 10);
      end else begin
        ts_cursor += $urandom_range(0, 8);
        f.stamp = ts_cursor;
      end
      f.seq = seq_cursor;
      f.key = ($urandom_range(0, 3) == 0);
      f.total = $urandom_range(601, 2400);
      f.sent = 0;
      if (plans.size() >= 4) void'(plans.pop_front());
      plans.push_back(f);
      idx = plans.size() - 1;
    end else begin
      idx = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, plans.size() - 1);
    end
    if (idx >= 0) begin
      f = plans[idx];
      chunk = $urandom_range(1, 600);
      if (chunk > f.total - f.sent) chunk = f.total - f.sent;
      p.seq_number = f.seq;
      p.time_stamp = f.stamp;
      p.key_frame = f.key;
      p.frame_offset = f.sent;
      p.frame_length = f.total;
      p.payload_length = chunk[15:0];
      if ($urandom_range(0, 19) != 0) begin
        f.sent += chunk;
        if (f.sent == f.total) plans.delete(idx);
        else plans[idx] = f;
      end
    end
    return p;
  endfunction

  task automatic run_stream(int count);
    repeat (count) send_pkt(next_stream_packet());
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    pkt_valid = 1'b0;
    pkt = '0;
    cfg_we = 1'b0;
    cfg_index = REG_HOLD;
    cfg_data = '0;
    idling_on = 1'b1;
    seq_cursor = 16'($urandom);
    ts_cursor = 32'd1000;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // invalid offsets at both ends of the range
    send_fields(16'h0000, 32'd0, 1'b0, 32'd0, 32'd0, 16'd0);
    send_fields(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_fields(16'd1, 32'd10, 1'b0, 32'd0, 32'd100, 16'd100);
    // keyframe in slot 0 holds back completions behind it
    send_fields(16'd2, 32'd20, 1'b1, 32'd0, 32'd300, 16'd100);
    send_fields(16'd3, 32'd21, 1'b0, 32'd0, 32'd200, 16'd100);
    send_fields(16'd3, 32'd21, 1'b0, 32'd100, 32'd200, 16'd100);
    send_fields(16'd4, 32'd22, 1'b0, 32'd0, 32'd50, 16'd50);
    // hold window: drop inside, evict at its edge
    send_fields(16'd5, 32'd30, 1'b0, 32'd0, 32'd400, 16'd200);
    send_fields(16'd5, 32'd35, 1'b0, 32'd0, 32'd400, 16'd200);
    send_fields(16'd6, 32'd36, 1'b1, 32'd0, 32'd1000, 16'd500);
    send_fields(16'd2, 32'd15, 1'b0, 32'd0, 32'd80, 16'd40);
    send_fields(16'd5, 32'd35, 1'b0, 32'd200, 32'd400, 16'd200);
    send_fields(16'd6, 32'd36, 1'b1, 32'd500, 32'd1000, 16'd500);
    // hold sum past 32 bits
    send_fields(16'd7, 32'hFFFF_FFF0, 1'b1, 32'd0, 32'd1000, 16'd10);
    send_fields(16'd8, 32'hFFFF_FFF5, 1'b0, 32'd0, 32'd1000, 16'd10);
    send_fields(16'd9, 32'hFFFF_FFFA, 1'b0, 32'd0, 32'd1000, 16'd10);
    send_fields(16'd10, 32'hFFFF_FFFE, 1'b0, 32'd0, 32'd1000, 16'd10);
    send_fields(16'd10, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd1000, 16'd10);
    send_fields(16'd11, 32'd0, 1'b0, 32'd0, 32'd1000, 16'd10);
    send_fields(16'd12, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd20, 16'd20);
    send_fields(16'd13, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd1000, 16'd10);
    // evict, write and release from one item
    send_fields(16'd14, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd30, 16'd30);

    write_config(REG_ENABLE, 16'd0);
    send_fields(16'h1234, 32'd50, 1'b0, 32'd0, 32'd10, 16'd5);
    send_fields(16'h4321, 32'd60, 1'b1, 32'd9, 32'd3, 16'd3);
    write_config(REG_ENABLE, 16'd1);

    write_config(REG_HOLD, 16'd0);
    ts_cursor = $urandom_range(0, 32'h7FFF_FFFF);
    run_stream(80);
    write_config(REG_HOLD, 16'hFFFF);
    ts_cursor = $urandom_range(0, 32'h7FFF_FFFF);
    run_stream(80);
    write_config(REG_ENABLE, 16'd0);
    run_stream(6);
    write_config(REG_ENABLE, 16'd1);
    write_config(REG_HOLD, 16'd20);
    run_stream(80);
    write_config(REG_HOLD, HOLD_RESET);
    idling_on = 1'b0;
    run_stream(40);

    pkt_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d packets: %0d writes, %0d releases, %0d drops, %0d invalid",
             sb.packets, sb.kind_seen[KIND_WRITE], sb.kind_seen[KIND_RELEASE],
             sb.kind_seen[KIND_DROP], sb.kind_seen[KIND_INVALID]);
    $display("hold times 0, 15, 20 and 65535 ms; reception switched off and back on");
    if (sb.errors == 0) begin
      $display("** video_frame_slot_reassembler: PASSED **");
    end else begin
      $display("** video_frame_slot_reassembler: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
design/vfsr_pkg.sv
design/vfsr_cell.sv
design/video_frame_slot_reassembler.sv
sim/testbench.sv
